### src/bds_pkg.sv
`default_nettype none
// Package for the baud divisor search core: word types and constants.
// No dependencies.
package bds_pkg;

    localparam int NumPrescalerCodes = 12;
    localparam logic [27:0] KernelClockReset = 28'd16000000;
    localparam logic [30:0] ErrInit = 31'h7FFFFFFF;
    localparam logic [3:0] LastCode = 4'(NumPrescalerCodes - 1);
    localparam int DivWidth = 30;

    typedef struct packed {
        logic [24:0] desired_baud;
        logic        prescaler_limited;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic        oversample_by_8;
        logic [3:0]  prescaler_code;
        logic [28:0] divisor;
        logic [30:0] baud_error;
    } out_word_t;

endpackage

`default_nettype wire

### src/baud_divisor_search_core.sv
`default_nettype none
// Baud divisor search: sequencer over mode and prescaler candidates with one
// shared restoring divider. Depends on bds_pkg.
// Search: a candidate runs the shared divider up to twice, after a prescaler
// division when the prescaler divides by 2 to 12; limited prescaler tries code 0 only.
// Throughput: one word at a time; in_stall is high until the result is taken.
// Reset: rst_n clears control and sets kernel clock to 16 MHz.
module baud_divisor_search_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bds_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output bds_pkg::out_word_t     out_word,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [27:0]       cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CAND  = 4'd1;
    localparam logic [3:0] S_TWICE = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_ACH   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    localparam logic [1:0] P_PRE = 2'd0;
    localparam logic [1:0] P_TW  = 2'd1;
    localparam logic [1:0] P_ACH = 2'd2;

    localparam int W = bds_pkg::DivWidth;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [27:0] kclk_reg;
    logic [24:0] baud_reg, baud_next;
    logic        lim_reg, lim_next;
    logic        mode_reg, mode_next;
    logic [3:0]  code_reg, code_next;
    logic [28:0] sclk_reg, sclk_next;
    logic [W-1:0] dv_reg, dv_next;
    logic [W:0]   rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] den_reg, den_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic        found_reg, found_next;
    logic        bmode_reg, bmode_next;
    logic [3:0]  bcode_reg, bcode_next;
    logic [28:0] bdiv_reg, bdiv_next;
    logic [30:0] berr_reg, berr_next;

    logic [28:0] base_clk;
    logic [W:0]  shifted, trial;
    logic [W-1:0] rdiv;
    logic [29:0] err;
    logic [3:0]  start_code;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_word  = '{found: found_reg, oversample_by_8: bmode_reg,
                         prescaler_code: bcode_reg, divisor: bdiv_reg,
                         baud_error: berr_reg};

    assign base_clk   = mode_reg ? {kclk_reg, 1'b0} : {1'b0, kclk_reg};
    assign shifted    = {rem_reg[W-1:0], quo_reg[W-1]};
    assign trial      = shifted - {1'b0, den_reg};
    assign rdiv       = {1'b0, quo_reg[W-1:1]} + {{(W-1){1'b0}}, quo_reg[0]};
    assign err        = ({5'd0, baud_reg} >= {1'b0, quo_reg[28:0]})
                      ? ({5'd0, baud_reg} - {1'b0, quo_reg[28:0]})
                      : ({1'b0, quo_reg[28:0]} - {5'd0, baud_reg});
    assign start_code = lim_reg ? 4'd0 : bds_pkg::LastCode;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        baud_next  = baud_reg;
        lim_next   = lim_reg;
        mode_next  = mode_reg;
        code_next  = code_reg;
        sclk_next  = sclk_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        bmode_next = bmode_reg;
        bcode_next = bcode_reg;
        bdiv_next  = bdiv_reg;
        berr_next  = berr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    baud_next  = in_word.desired_baud;
                    lim_next   = in_word.prescaler_limited;
                    mode_next  = 1'b0;
                    code_next  = in_word.prescaler_limited ? 4'd0 : bds_pkg::LastCode;
                    found_next = 1'b0;
                    bmode_next = 1'b0;
                    bcode_next = 4'd0;
                    bdiv_next  = '0;
                    berr_next  = bds_pkg::ErrInit;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                if (code_reg == 4'd0)
                begin
                    sclk_next  = base_clk;
                    state_next = S_TWICE;
                end
                else if (code_reg <= 4'd6)
                begin
                    quo_next   = {1'b0, base_clk};
                    rem_next   = '0;
                    den_next   = {{(W-5){1'b0}}, code_reg, 1'b0};
                    cnt_next   = 5'(W);
                    phase_next = P_PRE;
                    state_next = S_DIV;
                end
                else
                begin
                    sclk_next  = base_clk >> (code_reg - 4'd3);
                    state_next = S_TWICE;
                end
            end
            S_TWICE:
            begin
                if (baud_reg == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    quo_next   = {sclk_reg, 1'b0};
                    rem_next   = '0;
                    den_next   = {5'd0, baud_reg};
                    cnt_next   = 5'(W);
                    phase_next = P_TW;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (trial[W])
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    unique case (phase_reg)
                        P_PRE:   state_next = S_TWICE;
                        P_TW:    state_next = S_ACH;
                        default: state_next = S_CMP;
                    endcase
                end
                if (cnt_reg == 5'd1 && phase_reg == P_PRE)
                begin
                    sclk_next = trial[W] ? quo_reg[W-3:0] << 1
                                         : {quo_reg[W-3:0], 1'b1};
                end
            end
            S_ACH:
            begin
                if (rdiv == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    dv_next    = rdiv;
                    quo_next   = {1'b0, sclk_reg};
                    rem_next   = '0;
                    den_next   = rdiv;
                    cnt_next   = 5'(W);
                    phase_next = P_ACH;
                    state_next = S_DIV;
                end
            end
            S_CMP:
            begin
                if ({1'b0, err} < berr_reg)
                begin
                    berr_next  = {1'b0, err};
                    bmode_next = mode_reg;
                    bcode_next = code_reg;
                    bdiv_next  = dv_reg[28:0];
                    found_next = 1'b1;
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (code_reg != 4'd0)
                begin
                    code_next  = code_reg - 4'd1;
                    state_next = S_CAND;
                end
                else if (!mode_reg)
                begin
                    mode_next  = 1'b1;
                    code_next  = start_code;
                    state_next = S_CAND;
                end
                else
                begin
                    if (!found_reg)
                    begin
                        berr_next = '0;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kclk_reg  <= bds_pkg::KernelClockReset;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                kclk_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        baud_reg  <= baud_next;
        lim_reg   <= lim_next;
        mode_reg  <= mode_next;
        code_reg  <= code_next;
        sclk_reg  <= sclk_next;
        dv_reg    <= dv_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        bmode_reg <= bmode_next;
        bcode_reg <= bcode_next;
        bdiv_reg  <= bdiv_next;
        berr_reg  <= berr_next;
    end

`ifndef SYNTHESIS
    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("divider running with zero divisor");
    a_found_div: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.found) |-> (out_word.divisor != '0))
        else $error("found result with zero divisor");
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.found) |-> (out_word.baud_error == '0))
        else $error("empty result carries an error value");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CAND))
        else $error("accepted word did not start a search");
`endif

endmodule

`default_nettype wire
